// ===== rtl/core/cle_pkg.sv =====
// cle_pkg: shared types and codes for the circular list engine.
// Transfer payload structs, mode and status codes, cell control and FSM state.
// No dependencies.
`default_nettype none

package cle_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_APPEND    = 3'd1;
    localparam logic [2:0] MODE_INS_AFTER = 3'd2;
    localparam logic [2:0] MODE_SEARCH    = 3'd3;
    localparam logic [2:0] MODE_TRAVERSE  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [DATA_W-1:0] item_value;
        logic                     last_of_run;
    } t_out;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_APPEND,
        CELL_ROT,
        CELL_ROT_INS
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/circular_list_engine.sv =====
// Insert front/append and error results: the input transfer is registered in r_cmd, the result
// is formed in S_EXEC and registered in the output register. Search, insert-after and traverse
// rotate the cell row once per cycle in S_WALK, n times with n entries; output stalls can pause
// the rotation. One item at a time: the next input transfer is taken once the item's last result
// is in the output register.
// Reset clears the list count and the output valid, not the cells. Uses cle_pkg and cle_cell.
`default_nettype none

module circular_list_engine #(
    parameter int CAPACITY = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cle_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output cle_pkg::t_out       o_out_data
);
    import cle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state            r_state;
    t_state            n_state;
    t_in               r_cmd;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_step;
    logic [CW-1:0]     n_step;
    logic [CW-1:0]     r_limit;
    logic [CW-1:0]     n_limit;
    logic              r_hit;
    logic              n_hit;
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;
    logic              n_emit;
    t_cell_ctl         w_ctl;
    logic              w_can_load;
    logic              w_walk;
    logic              w_go;
    logic              w_last;
    logic              w_match;
    logic              w_empty;
    logic              w_full;
    logic signed [DATA_W-1:0] w_cell [CAPACITY];

    assign w_can_load = !r_out_valid || !i_out_stall;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CAP_C);
    assign w_walk     = ((r_cmd.mode == MODE_INS_AFTER) && !w_empty && !w_full)
                     || (((r_cmd.mode == MODE_SEARCH) || (r_cmd.mode == MODE_TRAVERSE))
                         && !w_empty);
    assign w_last     = (r_step == (r_limit - ONE_C));
    assign w_match    = (w_cell[0] == r_cmd.key);
    assign w_go       = ((r_cmd.mode == MODE_TRAVERSE) || w_last) ? w_can_load : 1'b1;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (w_walk) n_state = S_WALK;
                else if (w_can_load) n_state = S_IDLE;
            end
            S_WALK: if (w_go && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.data = r_cmd.value;
        n_emit     = 1'b0;
        n_out      = '{status: ST_OK, found: 1'b0, item_value: '0, last_of_run: 1'b1};
        n_count    = r_count;
        n_step     = r_step;
        n_limit    = r_limit;
        n_hit      = r_hit;
        unique case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                n_step  = '0;
                n_hit   = 1'b0;
                n_limit = r_count;
                if (!w_walk && w_can_load) begin
                    n_emit = 1'b1;
                    unique case (r_cmd.mode)
                        MODE_INS_FRONT, MODE_APPEND: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ctl.op = (r_cmd.mode == MODE_INS_FRONT) ? CELL_SHIFT
                                                                          : CELL_APPEND;
                                n_count  = r_count + ONE_C;
                            end
                        end
                        MODE_INS_AFTER: n_out.status = w_empty ? ST_EMPTY : ST_FULL;
                        MODE_SEARCH, MODE_TRAVERSE: n_out.status = ST_EMPTY;
                        default: n_out.status = ST_OK;
                    endcase
                end
            end
            S_WALK: begin
                if (w_go) begin
                    n_step   = r_step + ONE_C;
                    w_ctl.op = CELL_ROT;
                    if (w_match) n_hit = 1'b1;
                    if ((r_cmd.mode == MODE_INS_AFTER) && w_match && !r_hit) begin
                        w_ctl.op = CELL_ROT_INS;
                        n_count  = r_count + ONE_C;
                    end
                    if (r_cmd.mode == MODE_TRAVERSE) begin
                        n_emit                = 1'b1;
                        n_out.item_value      = w_cell[0];
                        n_out.last_of_run     = w_last;
                    end else if (w_last) begin
                        n_emit = 1'b1;
                        if (r_cmd.mode == MODE_SEARCH) begin
                            n_out.found = r_hit || w_match;
                        end else begin
                            n_out.status = (r_hit || w_match) ? ST_OK : ST_NOT_FOUND;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[gi+1];
        end
        cle_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_len   (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_hit   <= n_hit;
            if (n_emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) r_cmd <= i_in_data;
        r_limit <= n_limit;
        if (n_emit) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/cle_cell.sv =====
// cle_cell: one list position of the cell row, holding one value.
// Shifts, rotates or loads according to the broadcast control. Uses cle_pkg.
`default_nettype none

module cle_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  wire logic                              i_clk,
    input  wire cle_pkg::t_cell_ctl                i_ctl,
    input  wire logic [CW-1:0]                     i_len,
    input  wire logic signed [cle_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [cle_pkg::DATA_W-1:0] i_right,
    input  wire logic signed [cle_pkg::DATA_W-1:0] i_head,
    output logic signed [cle_pkg::DATA_W-1:0]      o_data
);
    import cle_pkg::*;

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_inner;
    logic                     w_tail;
    logic                     w_next;

    assign w_inner = (IDX_P1 < i_len);
    assign w_tail  = (IDX_P1 == i_len);
    assign w_next  = (IDX_C == i_len);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD: n_data = r_data;
            CELL_SHIFT: begin
                n_data = (IDX == 0) ? i_ctl.data : i_left;
            end
            CELL_APPEND: begin
                if (w_next) n_data = i_ctl.data;
            end
            CELL_ROT: begin
                if (w_inner) n_data = i_right;
                else if (w_tail) n_data = i_head;
            end
            CELL_ROT_INS: begin
                if (w_inner) n_data = i_right;
                else if (w_tail) n_data = i_head;
                else if (w_next) n_data = i_ctl.data;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/cle_checker.sv =====
// cle_checker: port-level checks for circular_list_engine, bound to the top level.
// Uses cle_pkg.
`default_nettype none

module cle_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire cle_pkg::t_out o_out_data
);
    import cle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in progress");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.last_of_run)
        else $error("error status on a non-final result");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            (o_out_data.status == ST_OK) && o_out_data.last_of_run
            && (o_out_data.item_value == '0))
        else $error("found flag on a bad result");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.item_value != '0) |-> (o_out_data.status == ST_OK))
        else $error("traverse value with error status");

endmodule

bind circular_list_engine cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
